FILE: rtl/lpc_pkg.sv
// Package for the LRU page cache: sizes, field widths, sequencer state and store command types.
// No dependencies.
package lpc_pkg;
  localparam int ENTRIES = 1024;
  localparam int TAG_BITS = 52;
  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  localparam int BN_BITS = 52;
  localparam int OCC_BITS = 11;
  localparam int CTR_BITS = 48;
  localparam int CAP_BITS = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_DONE
  } lpc_state_t;

  // Command from sequencer to the entry store: a read request and a write request with tag and rank.
  typedef struct packed {
    logic              rd;
    logic [IDX_BITS-1:0] rd_addr;
    logic              wr;
    logic [IDX_BITS-1:0] wr_addr;
    logic [TAG_BITS-1:0] wr_tag;
    logic [IDX_BITS-1:0] wr_rank;
  } lpc_mem_cmd_t;
endpackage

FILE: rtl/lru_page_cache_model.sv
// LRU page cache top level: sequencer, counters and the entry store.
// Depends on lpc_pkg and lpc_store.
//
// Fully associative LRU cache of block numbers. A request (start high while busy is low)
// carries block_number and is_write; one result appears later for exactly one cycle with
// done high, carrying hit, occupancy and three saturating counters. The receiver cannot
// stall. Tags and recency ranks live in memories with registered reads and are walked through
// a single read port, one slot a cycle: a first pass over the valid slots searches for the
// tag and, on a full store, the least recently used slot; a second pass ages the ranks below
// that of the chosen slot and writes back. done rises as busy falls, so a new request may
// be accepted in that same cycle.
// No clearing pass is needed after reset. Write capacity only while busy is low.
module lru_page_cache_model import lpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [BN_BITS-1:0]  block_number,
  input  logic                is_write,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data,
  output logic                done,
  output logic                hit,
  output logic [OCC_BITS-1:0] occupancy,
  output logic [CTR_BITS-1:0] read_total,
  output logic [CTR_BITS-1:0] read_hit_total,
  output logic [CTR_BITS-1:0] write_total
);
  localparam logic [CTR_BITS-1:0] CTR_MAX = '1;

  lpc_state_t state, state_next;
  logic [CAP_BITS-1:0] capacity;
  logic [CNT_BITS-1:0] valid_count;
  logic [TAG_BITS-1:0] tag;
  logic                wr_req;
  logic [CNT_BITS-1:0] idx;        // slot being issued
  logic                pend;       // read data valid this cycle
  logic [IDX_BITS-1:0] pend_addr;
  logic                found;
  logic [IDX_BITS-1:0] slot;
  logic [IDX_BITS-1:0] limit;      // ranks below this age by one
  logic                insert;     // miss into a free slot
  logic [CNT_BITS-1:0] cap_use;
  logic [TAG_BITS-1:0] rd_tag;
  logic [IDX_BITS-1:0] rd_rank;
  lpc_mem_cmd_t        cmd;

  // Clamp capacity into 1..ENTRIES.
  always_comb begin
    if (capacity == '0) cap_use = CNT_BITS'(1);
    else if ({1'b0, capacity} > (CAP_BITS+1)'(ENTRIES)) cap_use = CNT_BITS'(ENTRIES);
    else cap_use = CNT_BITS'(capacity);
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = (valid_count == '0) ? ST_AGE : ST_SCAN;
      ST_SCAN: if (pend && !(idx < valid_count)) state_next = ST_AGE;
      ST_AGE:  if (!(idx < valid_count) && !pend) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory commands: read while idx in range; age pass writes back, done writes an insert.
  always_comb begin
    cmd = '0;
    cmd.rd = (state == ST_SCAN || state == ST_AGE) && (idx < valid_count);
    cmd.rd_addr = idx[IDX_BITS-1:0];
    if (state == ST_AGE && pend) begin
      cmd.wr = 1'b1;
      cmd.wr_addr = pend_addr;
      cmd.wr_tag = rd_tag;
      if (pend_addr == slot) begin
        cmd.wr_rank = '0;
        if (!found) cmd.wr_tag = tag;
      end else if (rd_rank < limit) cmd.wr_rank = rd_rank + IDX_BITS'(1);
      else cmd.wr_rank = rd_rank;
    end else if (state == ST_DONE && insert) begin
      cmd.wr = 1'b1;
      cmd.wr_addr = slot;
      cmd.wr_tag = tag;
      cmd.wr_rank = '0;
    end
  end

  lpc_store u_store (.clk(clk), .cmd(cmd), .rd_tag(rd_tag), .rd_rank(rd_rank));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      capacity <= CAP_BITS'(1024);
      valid_count <= '0;
      read_total <= '0;
      read_hit_total <= '0;
      write_total <= '0;
      done <= 1'b0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_we) capacity <= cfg_data;
      pend <= cmd.rd;
      pend_addr <= cmd.rd_addr;
      case (state)
        ST_IDLE: begin
          if (start) begin
            tag <= block_number[TAG_BITS-1:0];
            wr_req <= is_write;
            idx <= '0;
            found <= 1'b0;
            insert <= (valid_count < cap_use);
            // Free slot: insertion at the end, everything ages.
            slot <= valid_count[IDX_BITS-1:0];
            limit <= valid_count[IDX_BITS-1:0];
            if (valid_count == '0) insert <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (cmd.rd) idx <= idx + CNT_BITS'(1);
          if (pend) begin
            if (rd_tag == tag && !found) begin
              found <= 1'b1;
              insert <= 1'b0;
              slot <= pend_addr;
              limit <= rd_rank;
            end else if (!found && !insert &&
                         {1'b0, rd_rank} == valid_count - CNT_BITS'(1)) begin
              slot <= pend_addr;
              limit <= rd_rank;
            end
            if (!cmd.rd) idx <= '0;
          end
        end
        ST_AGE: begin
          if (cmd.rd) idx <= idx + CNT_BITS'(1);
        end
        ST_DONE: begin
          done <= 1'b1;
          hit <= found;
          if (insert) valid_count <= valid_count + CNT_BITS'(1);
          occupancy <= OCC_BITS'(valid_count + (insert ? CNT_BITS'(1) : CNT_BITS'(0)));
          if (wr_req) begin
            if (write_total != CTR_MAX) write_total <= write_total + CTR_BITS'(1);
          end else begin
            if (read_total != CTR_MAX) read_total <= read_total + CTR_BITS'(1);
            if (found && read_hit_total != CTR_MAX)
              read_hit_total <= read_hit_total + CTR_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == ST_DONE)
    else $error("done without finish state");
  assert property (@(posedge clk) disable iff (rst) valid_count <= CNT_BITS'(ENTRIES))
    else $error("occupancy overflow");
  assert property (@(posedge clk) disable iff (rst) cmd.wr |-> state != ST_SCAN)
    else $error("write during search pass");
  assert property (@(posedge clk) disable iff (rst) done |-> !(hit && $past(insert)))
    else $error("hit flagged as insertion");
endmodule

FILE: rtl/lpc_store.sv
// Entry store: tag and recency rank memories, one read and one write port each.
// Depends on lpc_pkg.
module lpc_store import lpc_pkg::*; (
  input  logic                clk,
  input  lpc_mem_cmd_t        cmd,
  output logic [TAG_BITS-1:0] rd_tag,
  output logic [IDX_BITS-1:0] rd_rank
);
  logic [TAG_BITS-1:0] tags [ENTRIES];
  logic [IDX_BITS-1:0] ranks [ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      tags[cmd.wr_addr] <= cmd.wr_tag;
      ranks[cmd.wr_addr] <= cmd.wr_rank;
    end
    if (cmd.rd) begin
      rd_tag <= tags[cmd.rd_addr];
      rd_rank <= ranks[cmd.rd_addr];
    end
  end
endmodule

FILE: tb/tb_lru_page_cache_model.sv
// Testbench for lru_page_cache_model: directed table plus random accesses over several capacities.
// Depends on lpc_pkg and the RTL top level; checks every result against an in-bench LRU predictor.
`timescale 1ns / 100ps

module tb_lru_page_cache_model;
  import lpc_pkg::*;

  localparam int QUIET_LIMIT = 20000;  // well above the longest request plus a sender gap
  localparam logic [BN_BITS-1:0] BN_MAX = '1;

  typedef struct {
    logic                hit;
    logic [OCC_BITS-1:0] occ;
    logic [CTR_BITS-1:0] rd;
    logic [CTR_BITS-1:0] rd_hit;
    logic [CTR_BITS-1:0] wr;
  } cache_result_t;

  typedef struct {
    logic [BN_BITS-1:0]  bn;
    logic                wr;
    bit                  typed;  // hit and occupancy below are known by inspection
    logic                hit;
    logic [OCC_BITS-1:0] occ;
  } access_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [BN_BITS-1:0]  block_number;
  logic                is_write;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_data;
  logic                done;
  logic                hit;
  logic [OCC_BITS-1:0] occupancy;
  logic [CTR_BITS-1:0] read_total;
  logic [CTR_BITS-1:0] read_hit_total;
  logic [CTR_BITS-1:0] write_total;

  // Predictor state: tags ordered most recent first, counters and capacity in use.
  logic [TAG_BITS-1:0] recency_list[$];
  logic [CTR_BITS-1:0] reads_cnt, read_hits_cnt, writes_cnt;
  int                  cap_setting;
  cache_result_t       pending_results[$];
  bit                  failed;
  bit                  idle_on;
  int                  quiet_cycles;

  lru_page_cache_model dut (
    .clk, .rst, .start, .busy, .block_number, .is_write, .cfg_we, .cfg_data,
    .done, .hit, .occupancy, .read_total, .read_hit_total, .write_total
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Look the tag up, update recency order and counters, return the expected result.
  function automatic cache_result_t lru_access(logic [BN_BITS-1:0] bn, logic wr);
    cache_result_t r;
    logic [TAG_BITS-1:0] tag;
    int pos;
    int cap;
    tag = bn[TAG_BITS-1:0];
    cap = cap_setting;
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    pos = -1;
    foreach (recency_list[i]) begin
      if (pos < 0 && recency_list[i] == tag) pos = i;
    end
    r.hit = (pos >= 0);
    if (r.hit) begin
      recency_list.delete(pos);
    end else if (recency_list.size() >= cap) begin
      // evict the least recent; a lowered capacity never shrinks occupancy
      void'(recency_list.pop_back());
    end
    recency_list.push_front(tag);
    if (wr) begin
      if (writes_cnt != '1) writes_cnt++;
    end else begin
      if (reads_cnt != '1) reads_cnt++;
      if (r.hit && read_hits_cnt != '1) read_hits_cnt++;
    end
    r.occ = OCC_BITS'(recency_list.size());
    r.rd = reads_cnt;
    r.rd_hit = read_hits_cnt;
    r.wr = writes_cnt;
    return r;
  endfunction

  // Present one request from the falling edge and hold it until accepted.
  task automatic issue_request(access_row_t row);
    cache_result_t r;
    if (idle_on && $urandom_range(0, 99) < 9) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    block_number = row.bn;
    is_write = row.wr;
    do @(posedge clk); while (busy);
    r = lru_access(row.bn, row.wr);
    if (row.typed) begin
      r.hit = row.hit;
      r.occ = row.occ;
    end
    pending_results.push_back(r);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Drain outstanding results, then write capacity while the block is idle.
  task automatic set_capacity(logic [CAP_BITS-1:0] value);
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    cap_setting = int'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pick a block number: mostly from a small pool so hits occur, sometimes anything.
  function automatic logic [BN_BITS-1:0] pick_block(int pool);
    logic [BN_BITS-1:0] bn;
    if ($urandom_range(0, 99) < 15) begin
      bn = BN_BITS'({$urandom, $urandom});
    end else begin
      bn = BN_BITS'($urandom_range(0, pool - 1));
      if ($urandom_range(0, 1)) bn = BN_MAX - bn;  // exercise the high bits too
    end
    return bn;
  endfunction

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    cache_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: hit=%0b occ=%0d", $time, hit, occupancy);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (hit !== e.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
          failed = 1'b1;
        end
        if (occupancy !== e.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occupancy);
          failed = 1'b1;
        end
        if (read_total !== e.rd) begin
          $display("%0t: read_total expected %0d actual %0d", $time, e.rd, read_total);
          failed = 1'b1;
        end
        if (read_hit_total !== e.rd_hit) begin
          $display("%0t: read_hit_total expected %0d actual %0d", $time, e.rd_hit,
                   read_hit_total);
          failed = 1'b1;
        end
        if (write_total !== e.wr) begin
          $display("%0t: write_total expected %0d actual %0d", $time, e.wr, write_total);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run if no request or result moves for too long.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  access_row_t directed_rows[] = '{
    // empty cache at reset: first read misses
    '{52'h0, 1'b0, 1'b1, 1'b0, 11'd1},
    '{BN_MAX, 1'b1, 1'b1, 1'b0, 11'd2},
    '{52'h0, 1'b0, 1'b1, 1'b1, 11'd2},
    '{BN_MAX, 1'b0, 1'b1, 1'b1, 11'd2},
    '{52'h5_5555_5555_5555, 1'b1, 1'b1, 1'b0, 11'd3},
    '{52'hA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0, 11'd4},
    '{52'h5_5555_5555_5555, 1'b0, 1'b1, 1'b1, 11'd4},
    '{52'h1, 1'b1, 1'b0, 1'b0, 11'd0}
  };

  // After capacity drops to 2: occupancy holds at 5, a stored entry still hits, a new block misses.
  access_row_t shrink_rows[] = '{
    '{52'h0, 1'b0, 1'b1, 1'b1, 11'd5},
    '{52'h77, 1'b0, 1'b1, 1'b0, 11'd5},
    '{52'hA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 11'd0},
    '{52'h78, 1'b1, 1'b0, 1'b0, 11'd0}
  };

  int random_caps[] = '{4, 16, 1, 64, 0, 2047, 8, 3};

  initial begin
    access_row_t row;
    int pool;
    failed = 1'b0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    block_number = '0;
    is_write = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    cap_setting = ENTRIES;
    reads_cnt = '0;
    read_hits_cnt = '0;
    writes_cnt = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset capacity, then a shrink below occupancy, then zero and the top value.
    foreach (directed_rows[i]) issue_request(directed_rows[i]);
    set_capacity(11'd2);
    foreach (shrink_rows[i]) issue_request(shrink_rows[i]);
    set_capacity(11'd0);
    for (int i = 0; i < 4; i++) begin
      row = '{pick_block(3), 1'(i), 1'b0, 1'b0, 11'd0};
      issue_request(row);
    end
    set_capacity(11'd1024);
    for (int i = 0; i < 3; i++) begin
      row = '{52'(i), 1'b0, 1'b0, 1'b0, 11'd0};
      issue_request(row);
    end

    // Random phases across capacities; one phase runs with no sender gaps.
    foreach (random_caps[p]) begin
      set_capacity(11'(random_caps[p]));
      idle_on = (p != 3);
      pool = (random_caps[p] > 32) ? 40 : random_caps[p] + 3;
      for (int i = 0; i < 66; i++) begin
        row = '{pick_block(pool), 1'($urandom_range(0, 1)), 1'b0, 1'b0, 11'd0};
        issue_request(row);
      end
    end

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
